/* sv/pfe_pkg.sv */
// pfe_pkg: shared types and constants of the PWM fade engine.
// Word layouts of both channels, opcodes, sequencer states, divider status.
// No dependencies.
package pfe_pkg;

    localparam int CHAN_W           = 3;
    localparam int DUTY_W           = 8;
    localparam int TIME_W           = 16;
    localparam int OPCODE_W         = 2;
    localparam int STEP_LIMIT       = 127;
    localparam int DEF_NUM_CHANNELS = 4;
    // numerator 2*|delta| + time and divisor 2*time both fit here
    localparam int DIV_W            = TIME_W + 1;

    localparam logic [OPCODE_W-1:0] OP_SET  = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_TICK = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_STOP = 2'd2;
    localparam logic [OPCODE_W-1:0] OP_RSVD = 2'd3;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [CHAN_W-1:0]   channel;
        logic [DUTY_W-1:0]   target_duty;
        logic [TIME_W-1:0]   fade_time;
    } cmd_word_t;

    typedef struct packed {
        logic [CHAN_W-1:0] out_channel;
        logic [DUTY_W-1:0] duty;
        logic              write_strobe;
        logic              accepted;
        logic              last;
    } res_word_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_DIV,
        S_EMIT,
        S_TICK
    } fsm_state_t;

endpackage

/* sv/pfe_divider.sv */
// pfe_divider: restoring divider, one quotient bit per cycle.
// Used for the rounded fade step. Depends on pfe_pkg.
module pfe_divider (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [pfe_pkg::DIV_W-1:0] num,
    input  logic [pfe_pkg::DIV_W-1:0] den,
    output pfe_pkg::div_status_t      status,
    output logic [pfe_pkg::DIV_W-1:0] quot
);
    import pfe_pkg::*;

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0] num_reg, num_next;
    logic [DIV_W-1:0] den_reg, den_next;
    logic [DIV_W-1:0] rem_reg, rem_next;
    logic [DIV_W:0]   rem_shift;
    logic [DIV_W:0]   diff;
    logic             ge;

    assign rem_shift = {rem_reg, num_reg[DIV_W-1]};
    assign diff      = rem_shift - {1'b0, den_reg};
    assign ge        = rem_shift >= {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIV_W);
            num_next  = num;
            den_next  = den;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[DIV_W-1:0] : rem_shift[DIV_W-1:0];
            num_next = {num_reg[DIV_W-2:0], ge};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quot        = num_reg;

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider started while busy");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("divider done without a run");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && den_reg != '0) |-> (rem_reg < den_reg))
        else $error("partial remainder not below divisor");

endmodule

/* sv/pfe_out_stage.sv */
// pfe_out_stage: one-word output register between sequencer and result port.
// Depends on pfe_pkg.
module pfe_out_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push_valid,
    output logic               push_stall,
    input  pfe_pkg::res_word_t push_word,
    output logic               valid,
    input  logic               stall,
    output pfe_pkg::res_word_t word
);
    import pfe_pkg::*;

    logic      valid_reg, valid_next;
    res_word_t word_reg;
    logic      load;

    assign push_stall = valid_reg && stall;
    assign load       = push_valid && !push_stall;

    always_comb
    begin
        if (load)
            valid_next = 1'b1;
        else if (!stall)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            word_reg <= push_word;
    end

    assign valid = valid_reg;
    assign word  = word_reg;

endmodule

/* sv/pwm_fade_engine_unit.sv */
// pwm_fade_engine_unit: multi-channel PWM duty fader, top level.
// Sequence: a set/stop/reject word passes S_DECODE and S_EMIT before it loads the output register;
//   a fading set also waits in S_DIV on the shared restoring divider.
// Commands: a new command is taken only back in S_IDLE, once the last one is done. A tick
//   walks the channels up to the last mover in S_TICK; result stalls hold all of these.
// Reset: async active-low, all channel duty, target and step registers go to zero.
module pwm_fade_engine_unit #(
    parameter int NUM_CHANNELS = pfe_pkg::DEF_NUM_CHANNELS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_stall,
    input  pfe_pkg::cmd_word_t cmd,
    output logic               res_valid,
    input  logic               res_stall,
    output pfe_pkg::res_word_t res
);
    import pfe_pkg::*;

    localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    // sequencer
    fsm_state_t state_reg, state_next;
    cmd_word_t  cmd_reg;
    logic [CH_W-1:0]         idx_reg, idx_next;
    logic [NUM_CHANNELS-1:0] mask_reg, mask_next;
    res_word_t               hold_reg, hold_next;

    // per-channel state, small enough for flops with reset
    logic        [DUTY_W-1:0] cur_reg  [NUM_CHANNELS];
    logic        [DUTY_W-1:0] tgt_reg  [NUM_CHANNELS];
    logic signed [DUTY_W-1:0] step_reg [NUM_CHANNELS];

    logic [CH_W-1:0]          addr;
    logic [DUTY_W-1:0]        rd_cur, rd_tgt;
    logic signed [DUTY_W-1:0] rd_step;
    logic                     cur_we, tgt_we, step_we;
    logic [DUTY_W-1:0]        cur_wdata, tgt_wdata;
    logic signed [DUTY_W-1:0] step_wdata;

    // decode of the held command
    logic ch_ok, is_tick, is_reject, is_stop, is_imm;
    logic [NUM_CHANNELS-1:0] move_vec;

    // fade step arithmetic
    logic                neg;
    logic [DUTY_W-1:0]   mag;
    logic [DIV_W-1:0]    div_num, div_den, div_quot;
    logic                div_start;
    div_status_t         div_stat;
    logic [DUTY_W-2:0]   q_clamp;
    logic signed [DUTY_W-1:0] fade_step;

    // tick arithmetic
    logic signed [DUTY_W+1:0] sum, fin, moved;
    logic [DUTY_W-1:0]        tick_duty;
    logic [NUM_CHANNELS-1:0]  mask_clr;
    logic                     cur_moves;

    // output path
    logic      push_valid, push_stall;
    res_word_t push_word;

    assign addr    = (state_reg == S_TICK) ? idx_reg : cmd_reg.channel[CH_W-1:0];
    assign rd_cur  = cur_reg[addr];
    assign rd_tgt  = tgt_reg[addr];
    assign rd_step = step_reg[addr];

    assign ch_ok     = {1'b0, cmd_reg.channel} < (CHAN_W + 1)'(NUM_CHANNELS);
    assign is_tick   = cmd_reg.opcode == OP_TICK;
    assign is_reject = (cmd_reg.opcode == OP_RSVD) || !ch_ok;
    assign is_stop   = cmd_reg.opcode == OP_STOP;
    assign is_imm    = (rd_cur == cmd_reg.target_duty) || (cmd_reg.fade_time == '0);

    // channels that a tick will move: not at target and a live step
    always_comb
    begin
        for (int i = 0; i < NUM_CHANNELS; i++)
            move_vec[i] = (cur_reg[i] != tgt_reg[i]) && (step_reg[i] != '0);
    end

    // round(|delta| / time) = (2|delta| + time) / (2 time)
    assign neg     = cmd_reg.target_duty < rd_cur;
    assign mag     = neg ? (rd_cur - cmd_reg.target_duty) : (cmd_reg.target_duty - rd_cur);
    assign div_num = DIV_W'({mag, 1'b0}) + DIV_W'(cmd_reg.fade_time);
    assign div_den = {cmd_reg.fade_time, 1'b0};

    always_comb
    begin
        if (div_quot > DIV_W'(STEP_LIMIT))
            q_clamp = (DUTY_W - 1)'(STEP_LIMIT);
        else if (div_quot == '0)
            q_clamp = (DUTY_W - 1)'(1);
        else
            q_clamp = div_quot[DUTY_W-2:0];
        fade_step = neg ? -$signed({1'b0, q_clamp}) : $signed({1'b0, q_clamp});
    end

    // one step toward target, no overshoot, clamp to duty range
    assign sum = $signed({2'b00, rd_cur}) + $signed({{2{rd_step[DUTY_W-1]}}, rd_step});
    assign fin = $signed({2'b00, rd_tgt});

    always_comb
    begin
        if (!rd_step[DUTY_W-1])
            moved = (sum > fin) ? fin : sum;
        else
            moved = (sum < fin) ? fin : sum;
        if (moved < 0)
            tick_duty = '0;
        else if (moved > $signed((DUTY_W + 2)'(255)))
            tick_duty = '1;
        else
            tick_duty = moved[DUTY_W-1:0];
    end

    assign cur_moves = mask_reg[idx_reg];
    always_comb
    begin
        mask_clr          = mask_reg;
        mask_clr[idx_reg] = 1'b0;
    end

    pfe_divider u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .num    (div_num),
        .den    (div_den),
        .status (div_stat),
        .quot   (div_quot)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                    state_next = S_DECODE;
            end
            S_DECODE:
            begin
                priority if (is_tick)
                    state_next = (move_vec != '0) ? S_TICK : S_IDLE;
                else if (is_reject || is_stop || is_imm)
                    state_next = S_EMIT;
                else
                    state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_stat.done)
                    state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (!push_stall)
                    state_next = S_IDLE;
            end
            S_TICK:
            begin
                if (cur_moves && !push_stall && mask_clr == '0)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // outputs and datapath controls
    always_comb
    begin
        cmd_stall  = 1'b1;
        idx_next   = idx_reg;
        mask_next  = mask_reg;
        hold_next  = hold_reg;
        cur_we     = 1'b0;
        tgt_we     = 1'b0;
        step_we    = 1'b0;
        cur_wdata  = cmd_reg.target_duty;
        tgt_wdata  = cmd_reg.target_duty;
        step_wdata = '0;
        div_start  = 1'b0;
        push_valid = 1'b0;
        push_word  = hold_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd_stall = 1'b0;
            end
            S_DECODE:
            begin
                hold_next.out_channel  = cmd_reg.channel;
                hold_next.duty         = rd_cur;
                hold_next.write_strobe = 1'b0;
                hold_next.accepted     = 1'b1;
                hold_next.last         = 1'b1;
                priority if (is_tick)
                begin
                    mask_next = move_vec;
                    idx_next  = '0;
                end
                else if (is_reject)
                begin
                    hold_next.duty     = '0;
                    hold_next.accepted = 1'b0;
                end
                else if (is_stop)
                begin
                    tgt_we    = 1'b1;
                    tgt_wdata = rd_cur;
                    step_we   = 1'b1;
                end
                else if (is_imm)
                begin
                    cur_we                 = 1'b1;
                    tgt_we                 = 1'b1;
                    step_we                = 1'b1;
                    hold_next.duty         = cmd_reg.target_duty;
                    hold_next.write_strobe = 1'b1;
                end
                else
                begin
                    tgt_we    = 1'b1;
                    div_start = 1'b1;
                end
            end
            S_DIV:
            begin
                if (div_stat.done)
                begin
                    step_we    = 1'b1;
                    step_wdata = fade_step;
                end
            end
            S_EMIT:
            begin
                push_valid = 1'b1;
            end
            S_TICK:
            begin
                push_valid             = cur_moves;
                push_word.out_channel  = CHAN_W'(idx_reg);
                push_word.duty         = tick_duty;
                push_word.write_strobe = 1'b1;
                push_word.accepted     = 1'b1;
                push_word.last         = mask_clr == '0;
                if (!cur_moves)
                    idx_next = idx_reg + CH_W'(1);
                else if (!push_stall)
                begin
                    cur_we     = 1'b1;
                    cur_wdata  = tick_duty;
                    step_we    = tick_duty == rd_tgt;
                    mask_next  = mask_clr;
                    idx_next   = idx_reg + CH_W'(1);
                end
            end
            default:
            begin
                cmd_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            mask_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            mask_reg  <= mask_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_valid && !cmd_stall)
            cmd_reg <= cmd;
        hold_reg <= hold_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                cur_reg[i]  <= '0;
                tgt_reg[i]  <= '0;
                step_reg[i] <= '0;
            end
        end
        else
        begin
            if (cur_we)
                cur_reg[addr] <= cur_wdata;
            if (tgt_we)
                tgt_reg[addr] <= tgt_wdata;
            if (step_we)
                step_reg[addr] <= step_wdata;
        end
    end

    pfe_out_stage u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_stall (push_stall),
        .push_word  (push_word),
        .valid      (res_valid),
        .stall      (res_stall),
        .word       (res)
    );

    a_div_live: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (div_stat.busy || div_stat.done))
        else $error("waiting on divider that is not running");

    a_tick_mask: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_TICK) |-> (mask_reg != '0))
        else $error("channel walk with nothing left to move");

    a_reject_word: assert property (@(posedge clk) disable iff (!rst_n)
        (push_valid && !push_word.accepted) |->
            (push_word.duty == '0 && !push_word.write_strobe && push_word.last))
        else $error("rejected word carries duty or strobe");

    a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> (cmd_reg.fade_time != '0))
        else $error("divider started with zero fade time");

endmodule

/* verif/tb.sv */
// tb: self-checking testbench for pwm_fade_engine_unit.
// Directed table then random commands; results checked against a local fade predictor.
// Depends on pfe_pkg and pwm_fade_engine_unit.
module tb;

    import pfe_pkg::*;

    localparam int NCH        = DEF_NUM_CHANNELS;
    localparam int RAND_ITEMS = 405;
    localparam int DRAIN      = 60;      // covers the fading-set path through the divider
    localparam int LIMIT      = 600000;  // worst case: long gaps, 4 results per tick, long stalls

    logic      clk;
    logic      rst_n     = 1'b0;
    logic      cmd_valid = 1'b0;
    logic      cmd_stall;
    cmd_word_t cmd       = '0;
    logic      res_valid;
    logic      res_stall = 1'b0;
    res_word_t res;

    pwm_fade_engine_unit #(
        .NUM_CHANNELS(NCH)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd_valid(cmd_valid),
        .cmd_stall(cmd_stall),
        .cmd      (cmd),
        .res_valid(res_valid),
        .res_stall(res_stall),
        .res      (res)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Fade predictor: private copy of per-channel duty, target and step.
    // ------------------------------------------------------------------
    logic        [DUTY_W-1:0] m_duty   [NCH];
    logic        [DUTY_W-1:0] m_target [NCH];
    logic signed [DUTY_W-1:0] m_step   [NCH];

    res_word_t predicted_words[$];  // words caused by the command just taken
    res_word_t due_words[$];        // words still owed by the block, oldest first
    int        errors = 0;

    initial
    begin
        for (int i = 0; i < NCH; i++)
        begin
            m_duty[i]   = '0;
            m_target[i] = '0;
            m_step[i]   = '0;
        end
    end

    function automatic res_word_t mk_res(logic [CHAN_W-1:0] ch, logic [DUTY_W-1:0] duty,
                                         logic stb, logic acc, logic lst);
        res_word_t r;
        r.out_channel  = ch;
        r.duty         = duty;
        r.write_strobe = stb;
        r.accepted     = acc;
        r.last         = lst;
        return r;
    endfunction

    function automatic void fade_predict(cmd_word_t w);
        int cur;
        int fin;
        int st;
        int delta;
        int mag;
        int q;
        int last_mover;
        predicted_words.delete();
        if (w.opcode == OP_TICK)
        begin
            // find the final mover first so its word carries last
            last_mover = -1;
            for (int i = 0; i < NCH; i++)
                if (m_duty[i] != m_target[i] && m_step[i] != 0)
                    last_mover = i;
            for (int i = 0; i < NCH; i++)
            begin
                cur = int'(m_duty[i]);
                fin = int'(m_target[i]);
                st  = int'(m_step[i]);
                if (cur == fin || st == 0)
                    continue;
                // move one step, never past the target
                if (st > 0)
                    cur = (cur + st > fin) ? fin : cur + st;
                else
                    cur = (cur + st < fin) ? fin : cur + st;
                if (cur < 0)
                    cur = 0;
                if (cur > 255)
                    cur = 255;
                m_duty[i] = 8'(cur);
                if (cur == fin)
                    m_step[i] = '0;
                predicted_words.push_back(mk_res(3'(i), 8'(cur), 1'b1, 1'b1, i == last_mover));
            end
        end
        else if (w.opcode == OP_RSVD || w.channel >= NCH)
        begin
            // rejected: state untouched, duty reads zero
            predicted_words.push_back(mk_res(w.channel, '0, 1'b0, 1'b0, 1'b1));
        end
        else if (w.opcode == OP_STOP)
        begin
            m_target[w.channel] = m_duty[w.channel];
            m_step[w.channel]   = '0;
            predicted_words.push_back(mk_res(w.channel, m_duty[w.channel], 1'b0, 1'b1, 1'b1));
        end
        else if (m_duty[w.channel] == w.target_duty || w.fade_time == 0)
        begin
            // immediate set
            m_target[w.channel] = w.target_duty;
            m_duty[w.channel]   = w.target_duty;
            m_step[w.channel]   = '0;
            predicted_words.push_back(mk_res(w.channel, w.target_duty, 1'b1, 1'b1, 1'b1));
        end
        else
        begin
            // fade start: step = round(delta/time), ties away from zero, clamp, never zero
            delta = int'(w.target_duty) - int'(m_duty[w.channel]);
            mag   = (delta < 0) ? -delta : delta;
            q     = (2 * mag + int'(w.fade_time)) / (2 * int'(w.fade_time));
            if (q > STEP_LIMIT)
                q = STEP_LIMIT;
            if (q == 0)
                q = 1;
            m_target[w.channel] = w.target_duty;
            m_step[w.channel]   = (delta < 0) ? 8'(-q) : 8'(q);
            predicted_words.push_back(mk_res(w.channel, m_duty[w.channel], 1'b0, 1'b1, 1'b1));
        end
    endfunction

    // ------------------------------------------------------------------
    // Directed table. Typed rows carry their own expected word; the rest
    // lean on the predictor.
    // ------------------------------------------------------------------
    typedef struct {
        cmd_word_t w;
        bit        typed;
        res_word_t want;
    } dir_row_t;

    dir_row_t dir_rows[$];

    function automatic cmd_word_t mk_cmd(logic [OPCODE_W-1:0] op, int ch, int tgt, int ft);
        cmd_word_t w;
        w.opcode      = op;
        w.channel     = 3'(ch);
        w.target_duty = 8'(tgt);
        w.fade_time   = 16'(ft);
        return w;
    endfunction

    function automatic void add_row(logic [OPCODE_W-1:0] op, int ch, int tgt, int ft);
        dir_row_t r;
        r.w     = mk_cmd(op, ch, tgt, ft);
        r.typed = 1'b0;
        r.want  = '0;
        dir_rows.push_back(r);
    endfunction

    // single-word commands: expected word on the same channel with last set
    function automatic void add_typed(logic [OPCODE_W-1:0] op, int ch, int tgt, int ft,
                                      int duty, bit stb, bit acc);
        dir_row_t r;
        r.w     = mk_cmd(op, ch, tgt, ft);
        r.typed = 1'b1;
        r.want  = mk_res(3'(ch), 8'(duty), stb, acc, 1'b1);
        dir_rows.push_back(r);
    endfunction

    function automatic void build_table();
        add_row  (OP_TICK, 0,   0,     0);                // nothing fading after reset
        add_typed(OP_STOP, 0,   0,     0,   0, 0, 1);     // stop of an idle channel
        add_typed(OP_SET,  0, 255,     0, 255, 1, 1);     // zero fade time: immediate
        add_typed(OP_SET,  1,   0,   100,   0, 1, 1);     // target equals current duty
        add_typed(OP_SET,  4, 128,    10,   0, 0, 0);     // first channel out of range
        add_typed(OP_SET,  7, 255, 65535,   0, 0, 0);     // top channel, all-ones fields
        add_typed(OP_STOP, 5,   0,     0,   0, 0, 0);     // stop out of range
        add_typed(OP_RSVD, 2, 170, 21845,   0, 0, 0);     // unused opcode
        add_typed(OP_SET,  1, 255,     1,   0, 0, 1);     // step clamps to +127
        add_typed(OP_SET,  2,   1, 65535,   0, 0, 1);     // step rounds to 0, forced to +1
        add_typed(OP_SET,  3,   3,     2,   0, 0, 1);     // 1.5 rounds away to 2
        add_row  (OP_TICK, 0,   0,     0);
        add_row  (OP_TICK, 7, 255, 65535);                // tick ignores its other fields
        add_row  (OP_TICK, 0,   0,     0);                // ch1 lands on 255 without overshoot
        add_typed(OP_SET,  0,   0,     3, 255, 0, 1);     // falling fade, step -85
        add_typed(OP_SET,  3,   0, 65535,   3, 0, 1);     // falling, forced to -1
        add_row  (OP_TICK, 0,   0,     0);
        add_row  (OP_TICK, 0,   0,     0);
        add_row  (OP_STOP, 0,   0,     0);                // freeze mid-fade
        add_row  (OP_TICK, 0,   0,     0);
        add_row  (OP_SET,  2,   2,     4);
        add_row  (OP_SET,  1,   0,     2);                // step clamps to -127
        add_row  (OP_TICK, 0,   0,     0);
        add_row  (OP_TICK, 0,   0,     0);
        add_row  (OP_TICK, 0,   0,     0);
    endfunction

    // ------------------------------------------------------------------
    // Random commands: mostly in-range sets and ticks so fades run to
    // completion, plus stops, rejects and the unused opcode.
    // ------------------------------------------------------------------
    function automatic int pick_chan();
        return ($urandom_range(0, 99) < 90) ? $urandom_range(0, NCH - 1) : $urandom_range(NCH, 7);
    endfunction

    function automatic int pick_fade_time();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 10)
            return 0;
        else if (roll < 65)
            return $urandom_range(1, 16);
        else if (roll < 85)
            return $urandom_range(17, 300);
        else if (roll < 97)
            return $urandom_range(0, 65535);
        else
            return 65535;
    endfunction

    function automatic cmd_word_t rand_cmd();
        cmd_word_t w;
        int        roll;
        w    = cmd_word_t'(($bits(cmd_word_t))'($urandom));
        roll = $urandom_range(0, 99);
        if (roll < 35)
            w.opcode = OP_TICK;
        else if (roll < 77)
        begin
            w.opcode    = OP_SET;
            w.channel   = 3'(pick_chan());
            w.fade_time = 16'(pick_fade_time());
            // now and then aim at the current duty
            if (w.channel < NCH && $urandom_range(0, 9) == 0)
                w.target_duty = m_duty[w.channel];
        end
        else if (roll < 90)
        begin
            w.opcode  = OP_STOP;
            w.channel = 3'(pick_chan());
        end
        else if (roll < 95)
            w.opcode = OP_RSVD;
        else
        begin
            w.opcode  = ($urandom_range(0, 1) == 0) ? OP_SET : OP_STOP;
            w.channel = 3'($urandom_range(NCH, 7));
        end
        return w;
    endfunction

    // ------------------------------------------------------------------
    // Idle lengths: mostly short, a few long, with gap-free bursts.
    // ------------------------------------------------------------------
    int burst_left = 0;

    function automatic int span_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 75)
            return $urandom_range(1, 3);
        else if (roll < 95)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic int pick_gap();
        int roll;
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 3)
        begin
            burst_left = $urandom_range(20, 80);
            return 0;
        end
        else if (roll < 50)
            return 0;
        else
            return span_len();
    endfunction

    // Send one command word; prediction happens at the accepting edge.
    task automatic issue(cmd_word_t w, bit typed, res_word_t want);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd       <= w;
        cmd_valid <= 1'b1;
        do
            @(posedge clk);
        while (cmd_stall);
        fade_predict(w);
        if (typed)
            due_words.push_back(want);
        else
            foreach (predicted_words[k])
                due_words.push_back(predicted_words[k]);
    endtask

    // ------------------------------------------------------------------
    // Result side: random stall with calm stretches, and the checker.
    // ------------------------------------------------------------------
    int stall_left = 0;
    int calm_left  = 0;
    int stall_roll;

    always @(posedge clk)
    begin
        if (!rst_n)
            res_stall <= 1'b0;
        else if (calm_left > 0)
        begin
            calm_left--;
            res_stall <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            res_stall <= 1'b1;
        end
        else
        begin
            res_stall <= 1'b0;
            stall_roll = $urandom_range(0, 99);
            if (stall_roll < 3)
                calm_left = $urandom_range(40, 200);
            else if (stall_roll < 30)
                stall_left = span_len();
        end
    end

    function automatic void check_field(string name, int want, int got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            errors++;
        end
    endfunction

    res_word_t want_w;

    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
        begin
            if (due_words.size() == 0)
            begin
                $error("result word with none expected: out_channel %0d duty %0d",
                       res.out_channel, res.duty);
                errors++;
            end
            else
            begin
                want_w = due_words.pop_front();
                check_field("out_channel",  want_w.out_channel,  res.out_channel);
                check_field("duty",         want_w.duty,         res.duty);
                check_field("write_strobe", want_w.write_strobe, res.write_strobe);
                check_field("accepted",     want_w.accepted,     res.accepted);
                check_field("last",         want_w.last,         res.last);
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog.
    // ------------------------------------------------------------------
    int cycles = 0;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------
    initial
    begin
        build_table();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        foreach (dir_rows[k])
            issue(dir_rows[k].w, dir_rows[k].typed, dir_rows[k].want);
        repeat (RAND_ITEMS)
            issue(rand_cmd(), 1'b0, '0);
        cmd_valid <= 1'b0;
        while (due_words.size() != 0)
            @(posedge clk);
        // let any trailing tick walk finish; stray words get flagged
        repeat (DRAIN) @(posedge clk);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
